[rtl/core/swpr_pkg.sv]
// Shared types, widths, codes and reset values of the swipe peak-return detector.
// No dependencies; imported by every module of the block.

package swpr_pkg;

    localparam int ANGLE_FRAC_BITS = 7;

    localparam int ANGLE_W    = 16;
    localparam int BASE_W     = 32;
    localparam int DIFF_W     = BASE_W + 1;
    localparam int DEV_W      = 17;
    localparam int THR_W      = 15;
    localparam int ALPHA_W    = 16;
    localparam int PROD_W     = DIFF_W + ALPHA_W + 1;
    localparam int CNT_W      = 10;
    localparam int CMD_W      = 4;
    localparam int MAG_W      = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 2 * ANGLE_W;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRACK = 2'd1,
        PH_COOL  = 2'd2
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        DIR_NONE  = 4'h0,
        DIR_LEFT  = 4'h6,
        DIR_RIGHT = 4'h7,
        DIR_UP    = 4'h8,
        DIR_DOWN  = 4'hA
    } cmd_t;

    localparam logic [CFG_ADDR_W-1:0] REG_DEPART_THR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RETURN_THR = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_MIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COOL_FRAMES = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;
    localparam logic [CNT_W-1:0]   COOL_RESET  = 10'd60;
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    typedef struct packed {
        logic [THR_W-1:0]   depart_thr;
        logic [THR_W-1:0]   return_thr;
        logic [THR_W-1:0]   peak_min;
        logic [ALPHA_W-1:0] alpha;
        logic [CNT_W-1:0]   cool_frames;
    } cfg_t;

    typedef struct packed {
        cmd_t             command;
        logic             swipe_done;
        logic [MAG_W-1:0] peak_mag;
    } result_t;

    function automatic logic [THR_W-1:0] deg_reset(input int deg);
        int v;
        v = deg << ANGLE_FRAC_BITS;
        return (v > 32'sd32767) ? {THR_W{1'b1}} : v[THR_W-1:0];
    endfunction

    function automatic logic [DEV_W-1:0] abs_dev(input logic signed [DEV_W-1:0] v);
        return v[DEV_W-1] ? (~v + {{(DEV_W-1){1'b0}}, 1'b1}) : v;
    endfunction

    function automatic logic is_pos(input logic signed [DEV_W-1:0] v);
        return !v[DEV_W-1] && (v != '0);
    endfunction

endpackage

[rtl/core/swpr_cfg.sv]
// Configuration register file of the swipe peak-return detector.
// Depends on swpr_pkg.

module swpr_cfg
    import swpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depart_thr  <= deg_reset(25);
            cfg_reg.return_thr  <= deg_reset(10);
            cfg_reg.peak_min    <= deg_reset(25);
            cfg_reg.alpha       <= ALPHA_RESET;
            cfg_reg.cool_frames <= COOL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_DEPART_THR:  cfg_reg.depart_thr  <= cfg_wdata[THR_W-1:0];
                REG_RETURN_THR:  cfg_reg.return_thr  <= cfg_wdata[THR_W-1:0];
                REG_PEAK_MIN:    cfg_reg.peak_min    <= cfg_wdata[THR_W-1:0];
                REG_ALPHA:       cfg_reg.alpha       <= cfg_wdata[ALPHA_W-1:0];
                REG_COOL_FRAMES: cfg_reg.cool_frames <= cfg_wdata[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/swpr_core.sv]
// Detector state and single-pass frame logic: baseline filter, peak tracking,
// return test and cooldown. Depends on swpr_pkg.

module swpr_core
    import swpr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic signed [ANGLE_W-1:0] roll_angle,
    input  logic signed [ANGLE_W-1:0] pitch_angle,
    input  cfg_t                      cfg,
    output result_t                   result
);

    logic signed [BASE_W-1:0] base_roll_reg, base_roll_next;
    logic signed [BASE_W-1:0] base_pitch_reg, base_pitch_next;
    logic signed [DEV_W-1:0]  peak_reg, peak_next;
    logic                     on_pitch_reg, on_pitch_next;
    phase_t                   phase_reg, phase_next;
    logic [CNT_W-1:0]         cool_cnt_reg, cool_cnt_next;
    logic                     seeded_reg, seeded_next;
    cmd_t                     cmd_reg, cmd_next;

    logic signed [BASE_W-1:0] roll16, pitch16;
    logic signed [DIFF_W-1:0] d16r, d16p;
    logic signed [DEV_W-1:0]  dr, dp, cur, peak_upd;
    logic [DEV_W-1:0]         adr, adp, ac, apk_old, apk;
    logic signed [PROD_W-1:0] prod_r, prod_p, adj_r, adj_p;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     done;
    logic [MAG_W-1:0]         mag;

    assign roll16  = {roll_angle, 16'h0};
    assign pitch16 = {pitch_angle, 16'h0};
    assign d16r    = {roll16[BASE_W-1], roll16} - {base_roll_reg[BASE_W-1], base_roll_reg};
    assign d16p    = {pitch16[BASE_W-1], pitch16} - {base_pitch_reg[BASE_W-1], base_pitch_reg};
    assign dr      = d16r[DIFF_W-1:16];
    assign dp      = d16p[DIFF_W-1:16];
    assign adr     = abs_dev(dr);
    assign adp     = abs_dev(dp);

    assign prod_r = $signed({1'b0, cfg.alpha}) * d16r;
    assign prod_p = $signed({1'b0, cfg.alpha}) * d16p;
    assign adj_r  = prod_r + $signed(PROD_W'(32768));
    assign adj_p  = prod_p + $signed(PROD_W'(32768));

    assign cur      = on_pitch_reg ? dp : dr;
    assign ac       = abs_dev(cur);
    assign apk_old  = abs_dev(peak_reg);
    assign peak_upd = ((is_pos(cur) == is_pos(peak_reg)) && (ac > apk_old)) ? cur : peak_reg;
    assign apk      = abs_dev(peak_upd);
    assign cnt_inc  = (cool_cnt_reg == CNT_MAX) ? cool_cnt_reg : cool_cnt_reg + 1'b1;

    always_comb
    begin
        base_roll_next  = base_roll_reg;
        base_pitch_next = base_pitch_reg;
        peak_next       = peak_reg;
        on_pitch_next   = on_pitch_reg;
        phase_next      = phase_reg;
        cool_cnt_next   = cool_cnt_reg;
        seeded_next     = seeded_reg;
        cmd_next        = cmd_reg;
        done            = 1'b0;
        mag             = '0;

        if (!seeded_reg)
        begin
            base_roll_next  = roll16;
            base_pitch_next = pitch16;
            seeded_next     = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    base_roll_next  = base_roll_reg + adj_r[BASE_W+15:16];
                    base_pitch_next = base_pitch_reg + adj_p[BASE_W+15:16];
                    priority if ((adr >= DEV_W'(cfg.depart_thr)) && (adr >= adp))
                    begin
                        peak_next     = dr;
                        on_pitch_next = 1'b0;
                        phase_next    = PH_TRACK;
                    end
                    else if ((adp >= DEV_W'(cfg.depart_thr)) && (adp > adr))
                    begin
                        peak_next     = dp;
                        on_pitch_next = 1'b1;
                        phase_next    = PH_TRACK;
                    end
                    else
                    begin
                    end
                end
                PH_TRACK:
                begin
                    peak_next = peak_upd;
                    if (ac <= DEV_W'(cfg.return_thr))
                    begin
                        if (apk >= DEV_W'(cfg.peak_min))
                        begin
                            if (!on_pitch_reg)
                                cmd_next = is_pos(peak_upd) ? DIR_RIGHT : DIR_LEFT;
                            else
                                cmd_next = is_pos(peak_upd) ? DIR_DOWN : DIR_UP;
                            cool_cnt_next = '0;
                            phase_next    = PH_COOL;
                            done          = 1'b1;
                            mag           = apk[DEV_W-1] ? {MAG_W{1'b1}} : apk[MAG_W-1:0];
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                        base_roll_next  = roll16;
                        base_pitch_next = pitch16;
                    end
                end
                PH_COOL:
                begin
                    cool_cnt_next = cnt_inc;
                    if (cnt_inc >= cfg.cool_frames)
                    begin
                        cmd_next   = DIR_NONE;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_roll_reg  <= '0;
            base_pitch_reg <= '0;
            peak_reg       <= '0;
            on_pitch_reg   <= 1'b0;
            phase_reg      <= PH_IDLE;
            cool_cnt_reg   <= '0;
            seeded_reg     <= 1'b0;
            cmd_reg        <= DIR_NONE;
        end
        else if (step)
        begin
            base_roll_reg  <= base_roll_next;
            base_pitch_reg <= base_pitch_next;
            peak_reg       <= peak_next;
            on_pitch_reg   <= on_pitch_next;
            phase_reg      <= phase_next;
            cool_cnt_reg   <= cool_cnt_next;
            seeded_reg     <= seeded_next;
            cmd_reg        <= cmd_next;
        end
    end

    assign result.command    = cmd_next;
    assign result.swipe_done = done;
    assign result.peak_mag   = mag;

endmodule

[rtl/core/swipe_peak_return_detector_top.sv]
// Top level of the swipe peak-return detector: stream channels, input and
// result registers. Depends on swpr_pkg, swpr_cfg and swpr_core.
//
// Usage:
//   s_* channel takes one frame per transaction: roll and pitch angles in
//   2^-7 degree units. m_* channel returns exactly one result per frame:
//   the held direction command, the swipe flag on tuser and the peak
//   magnitude that goes with the flag (zero otherwise).
//   The cfg_* port writes one register per cycle with cfg_we high; write
//   only while no frame is in flight.
// Path: a frame accepted into the input register is processed when the result
//   register is free or being taken; its result is on m_* from then on.
// Throughput: one frame per cycle while m_tready does not stall the result; the
//   state update of one frame is a single pass (one multiply per axis,
//   compares and selects) between the input register and the result register.
// Reset: clears the baselines, tracking state and held command and loads
//   the register defaults; the first frame after reset seeds the baselines.
// Stall: while m_tready is low the result holds, one more frame may wait
//   in the input register, and then s_tready drops.

module swipe_peak_return_detector_top
    import swpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] roll_angle, [31:16] pitch_angle
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] command, [19:4] peak_magnitude, zero pad
    output logic                  m_tuser,   // [0] swipe_done
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t result;
    result_t result_reg;

    logic                      in_valid_reg;
    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic                      out_valid_reg;
    logic                      step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    swpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    swpr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .roll_angle  (roll_reg),
        .pitch_angle (pitch_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            roll_reg  <= s_tdata[ANGLE_W-1:0];
            pitch_reg <= s_tdata[2*ANGLE_W-1:ANGLE_W];
        end
        if (step)
            result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-CMD_W-MAG_W){1'b0}}, result_reg.peak_mag,
                       result_reg.command};
    assign m_tuser  = result_reg.swipe_done;

endmodule

[rtl/core/swpr_checker.sv]
// Port-level checks of the swipe peak-return detector, bound to the top level.
// Depends on swpr_pkg and swipe_peak_return_detector_top.

module swpr_checker
    import swpr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    logic [CMD_W-1:0] cmd;
    logic [MAG_W-1:0] mag;

    assign cmd = m_tdata[CMD_W-1:0];
    assign mag = m_tdata[CMD_W+MAG_W-1:CMD_W];

    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (cmd == DIR_NONE) || (cmd == DIR_LEFT) || (cmd == DIR_RIGHT)
                     || (cmd == DIR_UP) || (cmd == DIR_DOWN))
        else $error("invalid command code on result");

    a_swipe_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (cmd != DIR_NONE))
        else $error("swipe reported without a command");

    a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (mag == '0))
        else $error("peak magnitude nonzero without a swipe");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind swipe_peak_return_detector_top swpr_checker u_swpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/tb_swipe_peak_return_detector_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for swipe_peak_return_detector_top: directed and random swipes, with a
// frame-by-frame gesture predictor and a result queue. Depends on swpr_pkg and the DUT.

module tb_swipe_peak_return_detector_top;
    import swpr_pkg::*;

    localparam int ANGLE_MAX   = 23040;
    localparam int CYCLE_LIMIT = 400000;

    class swipe_result_board;
        cfg_t        regs;
        int          base_roll;
        int          base_pitch;
        longint      peak;
        bit          peak_on_pitch;
        phase_t      state;
        int unsigned cool_count;
        bit          seeded;
        cmd_t        held;
        result_t     expected_swipes[$];
        int          errors;
        int          swipes;

        function new();
            regs.depart_thr  = 15'd3200;
            regs.return_thr  = 15'd1280;
            regs.peak_min    = 15'd3200;
            regs.alpha       = ALPHA_RESET;
            regs.cool_frames = COOL_RESET;
            base_roll     = 0;
            base_pitch    = 0;
            peak          = 0;
            peak_on_pitch = 1'b0;
            state         = PH_IDLE;
            cool_count    = 0;
            seeded        = 1'b0;
            held          = DIR_NONE;
            errors        = 0;
            swipes        = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEPART_THR:  regs.depart_thr  = val[THR_W-1:0];
                REG_RETURN_THR:  regs.return_thr  = val[THR_W-1:0];
                REG_PEAK_MIN:    regs.peak_min    = val[THR_W-1:0];
                REG_ALPHA:       regs.alpha       = val[ALPHA_W-1:0];
                REG_COOL_FRAMES: regs.cool_frames = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int roll_base();
            return base_roll >>> 16;
        endfunction

        function int pitch_base();
            return base_pitch >>> 16;
        endfunction

        function int pending();
            return expected_swipes.size();
        endfunction

        function void note_frame(logic signed [ANGLE_W-1:0] roll,
                                 logic signed [ANGLE_W-1:0] pitch);
            longint  r16, p16, d16r, d16p, dr, dp, adr, adp, cur, acur, apk;
            longint  alpha, dep, ret, pmin;
            result_t want;
            want  = '0;
            alpha = regs.alpha;
            dep   = regs.depart_thr;
            ret   = regs.return_thr;
            pmin  = regs.peak_min;
            r16   = longint'(roll) * 65536;
            p16   = longint'(pitch) * 65536;
            if (!seeded)
            begin
                base_roll  = int'(r16);
                base_pitch = int'(p16);
                seeded     = 1'b1;
            end
            else
            begin
                d16r = r16 - longint'(base_roll);
                d16p = p16 - longint'(base_pitch);
                dr   = d16r >>> 16;
                dp   = d16p >>> 16;
                adr  = (dr < 0) ? -dr : dr;
                adp  = (dp < 0) ? -dp : dp;
                case (state)
                    PH_IDLE:
                    begin
                        base_roll  = int'(longint'(base_roll) + ((alpha * d16r + 32768) >>> 16));
                        base_pitch = int'(longint'(base_pitch) + ((alpha * d16p + 32768) >>> 16));
                        if (adr >= dep && adr >= adp)
                        begin
                            peak          = dr;
                            peak_on_pitch = 1'b0;
                            state         = PH_TRACK;
                        end
                        else if (adp >= dep && adp > adr)
                        begin
                            peak          = dp;
                            peak_on_pitch = 1'b1;
                            state         = PH_TRACK;
                        end
                    end
                    PH_TRACK:
                    begin
                        cur  = peak_on_pitch ? dp : dr;
                        acur = (cur < 0) ? -cur : cur;
                        apk  = (peak < 0) ? -peak : peak;
                        if (((cur > 0) == (peak > 0)) && acur > apk)
                            peak = cur;
                        apk = (peak < 0) ? -peak : peak;
                        if (acur <= ret)
                        begin
                            if (apk >= pmin)
                            begin
                                if (peak_on_pitch)
                                begin
                                    if (peak > 0)
                                        held = DIR_DOWN;
                                    else
                                        held = DIR_UP;
                                end
                                else
                                begin
                                    if (peak > 0)
                                        held = DIR_RIGHT;
                                    else
                                        held = DIR_LEFT;
                                end
                                cool_count      = 0;
                                state           = PH_COOL;
                                want.swipe_done = 1'b1;
                                want.peak_mag   = (apk > 65535) ? 16'hFFFF : apk[MAG_W-1:0];
                                swipes++;
                            end
                            else
                                state = PH_IDLE;
                            base_roll  = int'(r16);
                            base_pitch = int'(p16);
                        end
                    end
                    PH_COOL:
                    begin
                        if (cool_count < CNT_MAX)
                            cool_count++;
                        if (cool_count >= regs.cool_frames)
                        begin
                            held  = DIR_NONE;
                            state = PH_IDLE;
                        end
                    end
                    default: state = PH_IDLE;
                endcase
            end
            want.command = held;
            expected_swipes.push_back(want);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic flag);
            result_t want;
            if (expected_swipes.size() == 0)
            begin
                report("result transaction with no frame outstanding");
                return;
            end
            want = expected_swipes.pop_front();
            if (data[CMD_W-1:0] !== want.command)
                report($sformatf("command %0h, expected %0h", data[CMD_W-1:0], want.command));
            if (flag !== want.swipe_done)
                report($sformatf("swipe_done %b, expected %b", flag, want.swipe_done));
            if (data[CMD_W+MAG_W-1:CMD_W] !== want.peak_mag)
                report($sformatf("peak_magnitude %0d, expected %0d",
                                 data[CMD_W+MAG_W-1:CMD_W], want.peak_mag));
            if (data[OUT_DATA_W-1:CMD_W+MAG_W] !== '0)
                report($sformatf("pad bits %b", data[OUT_DATA_W-1:CMD_W+MAG_W]));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    swipe_result_board board;
    bit                steady;
    int                frames_sent = 0;
    int                settings    = 0;
    int                cycles      = 0;

    swipe_peak_return_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic signed [ANGLE_W-1:0] clamp_angle(longint v);
        if (v > ANGLE_MAX)
            return ANGLE_W'(ANGLE_MAX);
        if (v < -ANGLE_MAX)
            return ANGLE_W'(-ANGLE_MAX);
        return v[ANGLE_W-1:0];
    endfunction

    function automatic longint jitter(longint bound);
        longint mag;
        mag = $urandom_range(0, int'(bound));
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic longint random_angle();
        return longint'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
    endfunction

    function automatic int pick_thr(int lo, int hi);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return ANGLE_MAX;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic send_frame(longint roll, longint pitch);
        logic signed [ANGLE_W-1:0] r;
        logic signed [ANGLE_W-1:0] p;
        r = clamp_angle(roll);
        p = clamp_angle(pitch);
        if (!steady && $urandom_range(0, 99) < 3)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p, r};
        do @(posedge clk); while (!s_tready);
        board.note_frame(r, p);
        frames_sent++;
    endtask

    // offsets are taken from the current baselines
    task automatic send_offset(bit on_pitch, longint main_off, longint side_off);
        longint r;
        longint p;
        r = board.roll_base() + (on_pitch ? side_off : main_off);
        p = board.pitch_base() + (on_pitch ? main_off : side_off);
        send_frame(r, p);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic program_regs(int dep, int ret, int pmin, int alpha, int cool);
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
        // unused index: must be ignored
        write_reg(REG_COOL_FRAMES + CFG_ADDR_W'(1 + $urandom_range(0, 2)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_DEPART_THR, CFG_DATA_W'(dep));
        write_reg(REG_RETURN_THR, CFG_DATA_W'(ret));
        write_reg(REG_PEAK_MIN, CFG_DATA_W'(pmin));
        write_reg(REG_ALPHA, CFG_DATA_W'(alpha));
        write_reg(REG_COOL_FRAMES, CFG_DATA_W'(cool));
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic do_swipe();
        bit     on_pitch;
        longint sgn, amp, dep, ret, quiet, steps, off;
        dep      = board.regs.depart_thr;
        ret      = board.regs.return_thr;
        on_pitch = 1'($urandom_range(0, 1));
        sgn      = $urandom_range(0, 1) ? 1 : -1;
        amp      = ($urandom_range(0, 7) == 0) ? dep : $urandom_range(int'(dep), ANGLE_MAX);
        quiet    = dep / 4;
        if (quiet > 400)
            quiet = 400;
        repeat ($urandom_range(0, 3)) send_offset(on_pitch, jitter(quiet), jitter(quiet));
        steps = $urandom_range(1, 3);
        for (int k = 1; k <= steps; k++)
            send_offset(on_pitch, sgn * amp * k / steps, jitter(quiet));
        repeat ($urandom_range(0, 3))
        begin
            off = $urandom_range(int'(ret), int'(amp > ret ? amp : ret));
            if ($urandom_range(0, 4) == 0)
                off = -off;
            send_offset(on_pitch, sgn * off, random_angle());
        end
        off = ($urandom_range(0, 3) == 0) ? ret : $urandom_range(0, int'(ret));
        if ($urandom_range(0, 1))
            off = -off;
        send_offset(on_pitch, off, random_angle());
        repeat (board.regs.cool_frames + $urandom_range(0, 3))
            send_frame(random_angle(), random_angle());
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 3)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int dep;
        int phase_num;
        board     = new();
        phase_num = 0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // seed, zero deviation, depart tie, left swipe under reset settings
        send_frame(ANGLE_MAX, -ANGLE_MAX);
        send_frame(ANGLE_MAX, -ANGLE_MAX);
        send_frame(0, 0);
        send_offset(1'b0, 0, 0);
        send_frame(-ANGLE_MAX, ANGLE_MAX);

        program_regs(1000, 500, 1000, 65535, 1);
        send_offset(1'b0, 0, 0);
        send_offset(1'b0, 2000, 0);
        send_offset(1'b0, 3000, 0);
        send_offset(1'b0, 100, 0);
        send_offset(1'b0, 0, 0);
        send_offset(1'b1, -2000, 100);
        send_offset(1'b1, -500, 0);
        send_offset(1'b1, 0, 0);
        send_offset(1'b1, 2500, -100);
        send_offset(1'b1, -3000, 0);
        send_offset(1'b1, 20, 0);
        send_offset(1'b0, 0, 0);

        // zero peak on roll with all thresholds at zero
        program_regs(0, 0, 0, 0, 1);
        send_offset(1'b0, 0, 0);
        send_offset(1'b0, 0, 0);
        send_offset(1'b0, 0, 0);

        // cancel: peak below the minimum
        program_regs(500, 200, ANGLE_MAX, 32768, 5);
        send_offset(1'b0, 1000, 0);
        send_offset(1'b0, 0, 0);
        send_frame(-ANGLE_MAX, -ANGLE_MAX);

        while (frames_sent < 700)
        begin
            dep = pick_thr(300, 6000);
            program_regs(dep, pick_thr(0, dep), pick_thr(0, dep < 21040 ? dep + 2000 : ANGLE_MAX),
                         ($urandom_range(0, 5) == 0) ? 0 :
                         ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 65535),
                         ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 20));
            steady = (phase_num % 5 == 3);
            repeat (6)
            begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 5)) send_frame(random_angle(), random_angle());
                else
                    do_swipe();
            end
            phase_num++;
        end
        steady = 1'b0;

        // long cooldown
        program_regs(100, ANGLE_MAX, 0, 65535, 250);
        do_swipe();

        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("%0d frames over %0d register settings, %0d swipes confirmed, %0d mismatches",
                 frames_sent, settings, board.swipes, board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
